FILE: hdl/pss_pkg.sv
// Package for the polyphonic sine synthesizer: voice word, envelope stage codes,
// command and register codes, and the elaboration-time sine and pitch helpers.
// No dependencies.
package pss_pkg;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
    localparam logic [1:0] CMD_NOTE_OFF = 2'd2;

    localparam logic [2:0] CFG_MASTER_GAIN    = 3'd0;
    localparam logic [2:0] CFG_ATTACK_STEP    = 3'd1;
    localparam logic [2:0] CFG_DECAY_STEP     = 3'd2;
    localparam logic [2:0] CFG_SUSTAIN_LEVEL  = 3'd3;
    localparam logic [2:0] CFG_RELEASE_STEP   = 3'd4;
    localparam logic [2:0] CFG_LFO_SHAPE      = 3'd5;
    localparam logic [2:0] CFG_LFO_PHASE_STEP = 3'd6;
    localparam logic [2:0] CFG_TREMOLO_DEPTH  = 3'd7;

    localparam logic [1:0] LFO_SINE     = 2'd0;
    localparam logic [1:0] LFO_TRIANGLE = 2'd1;
    localparam logic [1:0] LFO_SQUARE   = 2'd2;
    localparam logic [1:0] LFO_SAW      = 2'd3;

    localparam logic [23:0] FULL_LEVEL = 24'h800000;

    // 440 * 2^((k-69)/12) Hz in Q24 for notes 0 to 11.
    localparam logic [31:0] SEMITONE_Q24 [12] = '{
        32'd137167144, 32'd145323527, 32'd153964914, 32'd163120144,
        32'd172819773, 32'd183096170, 32'd193983636, 32'd205518503,
        32'd217739269, 32'd230686720, 32'd244404066, 32'd258937088
    };

    typedef enum logic [2:0] {
        ST_OFF     = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } stage_t;

    typedef struct packed {
        logic [6:0]  pitch;
        logic [15:0] tag;
        logic [16:0] velocity;
        logic [31:0] phase;
        stage_t      stage;
        logic [23:0] level;
    } voice_t;

    typedef struct packed {
        logic [23:0] attack_step;
        logic [23:0] decay_step;
        logic [23:0] sustain_level;
        logic [23:0] release_step;
    } env_cfg_t;

    // Sine of a Q32 turn in Q15 by an odd degree-nine polynomial; used only
    // to build the sine table at elaboration.
    function automatic logic signed [15:0] sine_q15(input logic [63:0] turn);
        logic [1:0]  quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        quad = turn[31:30];
        r = {34'd0, turn[29:0]};
        if (quad[0]) begin
            r = 64'd1073741824 - r;
        end
        x  = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t  = 64'd1073741824 - x2 / 64'd72;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        q  = (s + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return quad[1] ? -$signed({1'b0, q[14:0]}) : $signed({1'b0, q[14:0]});
    endfunction

endpackage

FILE: hdl/pss_voice_mem.sv
// Voice state memory: one voice word per entry, one write and one registered read port.
// Depends on pss_pkg for the voice word type.
module pss_voice_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            aclk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  pss_pkg::voice_t wdata,
    input  logic [AW-1:0]   raddr,
    output pss_pkg::voice_t rdata
);
    import pss_pkg::*;

    voice_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/pss_sine_rom.sv
// Sine table built at elaboration, read with one registered port.
// Depends on pss_pkg for the sine polynomial.
module pss_sine_rom #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int IW               = 10
) (
    input  logic                aclk,
    input  logic [IW-1:0]       addr,
    output logic signed [15:0]  data
);
    import pss_pkg::*;

    logic signed [15:0] rom [SINE_TABLE_DEPTH];

    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
        localparam longint unsigned TURN =
            (longint'(gi) << 32) / longint'(SINE_TABLE_DEPTH);
        assign rom[gi] = sine_q15(64'(TURN));
    end

    always_ff @(posedge aclk) begin
        data <= rom[addr];
    end

endmodule

FILE: hdl/pss_env.sv
// Linear ADSR envelope step for one voice.
// Depends on pss_pkg for stage codes and the envelope settings struct.
module pss_env (
    input  pss_pkg::stage_t   stage,
    input  logic [23:0]       level,
    input  pss_pkg::env_cfg_t cfg,
    output pss_pkg::stage_t   stage_next,
    output logic [23:0]       level_next
);
    import pss_pkg::*;

    logic [23:0]        sus;
    logic [24:0]        rise;
    logic signed [25:0] fall_d;
    logic signed [25:0] fall_r;

    always_comb begin
        sus    = (cfg.sustain_level > FULL_LEVEL) ? FULL_LEVEL : cfg.sustain_level;
        rise   = {1'b0, level} + {1'b0, cfg.attack_step};
        fall_d = $signed({2'b00, level}) - $signed({2'b00, cfg.decay_step});
        fall_r = $signed({2'b00, level}) - $signed({2'b00, cfg.release_step});
        stage_next = stage;
        level_next = 24'd0;
        unique case (stage)
            ST_ATTACK: begin
                if (rise >= {1'b0, FULL_LEVEL}) begin
                    level_next = FULL_LEVEL;
                    stage_next = ST_DECAY;
                end else begin
                    level_next = rise[23:0];
                end
            end
            ST_DECAY: begin
                if (fall_d <= $signed({2'b00, sus})) begin
                    level_next = sus;
                    stage_next = ST_SUSTAIN;
                end else begin
                    level_next = fall_d[23:0];
                end
            end
            ST_SUSTAIN: begin
                level_next = sus;
            end
            ST_RELEASE: begin
                if (fall_r <= 26'sd0) begin
                    level_next = 24'd0;
                    stage_next = ST_OFF;
                end else begin
                    level_next = fall_r[23:0];
                end
            end
            default: begin
                level_next = 24'd0;
            end
        endcase
    end

endmodule

FILE: hdl/polyphonic_sine_synth_adsr.sv
// Top level of the polyphonic sine synthesizer with ADSR envelopes and tremolo.
// Depends on pss_pkg, pss_voice_mem, pss_sine_rom and pss_env.
//
//  Channel   Ports                                   Moves
//  s_ (in)   s_valid/s_ready, s_command, s_note_*    one command word
//  m_ (out)  m_valid/m_ready, m_audio_sample         one mixed sample word per tick
//  cfg       cfg_we, cfg_index, cfg_data             register write, no wait
//
// A note-off and a tick both walk the voice memory one voice per cycle through
// its single read port, and a tick then drains the voice pipeline and runs a
// short mixing sequence.
// Reset is synchronous and active low; it loads the register defaults and clears
// the voice active flags, which also mark memory entries as holding no voice.
// A new word is taken only while idle; a finished sample waits in the output
// register, and a tick only stalls at its very end if that register is still full.
module polyphonic_sine_synth_adsr #(
    parameter int VOICE_COUNT      = 16,
    parameter int OUT_RATE_HZ      = 48000,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [6:0]         s_note_pitch,
    input  logic [16:0]        s_note_velocity,
    input  logic [15:0]        s_note_tag,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_audio_sample,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import pss_pkg::*;

    localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int CW = $clog2(VOICE_COUNT + 1);
    localparam int IW = $clog2(SINE_TABLE_DEPTH);
    localparam logic [16:0] DEPTH_K  = 17'(SINE_TABLE_DEPTH);
    localparam logic [CW-1:0] LAST_V = CW'(VOICE_COUNT - 1);
    localparam logic [CW-1:0] LFO_SLOT = CW'(VOICE_COUNT);

    typedef enum logic [3:0] {
        S_IDLE, S_NOTE_ON, S_SWEEP, S_DRAIN,
        S_MIX0, S_MIX1, S_MIX2, S_MIX3, S_OUT
    } state_t;

    // Configuration registers.
    logic [16:0] master_gain_reg;
    logic [23:0] attack_step_reg;
    logic [23:0] decay_step_reg;
    logic [23:0] sustain_level_reg;
    logic [23:0] release_step_reg;
    logic [1:0]  lfo_shape_reg;
    logic [31:0] lfo_phase_step_reg;
    logic [16:0] tremolo_depth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_gain_reg    <= 17'd32768;
            attack_step_reg    <= 24'd17476;
            decay_step_reg     <= 24'd524;
            sustain_level_reg  <= 24'd5872026;
            release_step_reg   <= 24'd612;
            lfo_shape_reg      <= LFO_SINE;
            lfo_phase_step_reg <= 32'd447392;
            tremolo_depth_reg  <= 17'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MASTER_GAIN:    master_gain_reg    <= cfg_data[16:0];
                CFG_ATTACK_STEP:    attack_step_reg    <= cfg_data[23:0];
                CFG_DECAY_STEP:     decay_step_reg     <= cfg_data[23:0];
                CFG_SUSTAIN_LEVEL:  sustain_level_reg  <= cfg_data[23:0];
                CFG_RELEASE_STEP:   release_step_reg   <= cfg_data[23:0];
                CFG_LFO_SHAPE:      lfo_shape_reg      <= cfg_data[1:0];
                CFG_LFO_PHASE_STEP: lfo_phase_step_reg <= cfg_data;
                CFG_TREMOLO_DEPTH:  tremolo_depth_reg  <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Phase increment per MIDI note, computed at elaboration.
    logic [31:0] pitch_tab [128];
    for (genvar gn = 0; gn < 128; gn++) begin : g_pitch
        localparam longint unsigned FREQ =
            longint'(SEMITONE_Q24[gn % 12]) << (gn / 12);
        localparam longint unsigned INC = (FREQ << 8) / longint'(OUT_RATE_HZ);
        assign pitch_tab[gn] = INC[31:0];
    end

    state_t      state_reg;
    logic [1:0]  cmd_reg;
    logic [6:0]  pitch_reg;
    logic [16:0] vel_reg;
    logic [15:0] tag_reg;
    logic [CW-1:0] cnt_reg;
    logic [VOICE_COUNT-1:0] active_reg;
    logic [31:0] lfo_phase_reg;
    logic        m_valid_reg;
    logic signed [15:0] m_sample_reg;

    // Voice pipeline registers.
    logic          p1_vld, p1_lfo;
    logic [VW-1:0] p1_addr;
    logic          p2_vld, p2_lfo;
    logic [48:0]   p2_prod;
    logic [16:0]   p2_vel;
    logic [23:0]   p2_lvl;
    logic          p3_vld, p3_lfo;
    logic [16:0]   p3_vel;
    logic [23:0]   p3_lvl;
    logic          p4_vld;
    logic signed [33:0] p4_m1;
    logic [23:0]   p4_lvl;
    logic          p5_vld;
    logic signed [57:0] p5_m2;
    logic signed [63:0] acc_reg;
    logic signed [15:0] lfo_sin_reg;

    // Mixing registers.
    logic [16:0]        lfo_val_reg;
    logic signed [37:0] ga_reg;
    logic signed [36:0] gb_reg;
    logic [33:0]        trem_prod_reg;
    logic signed [40:0] s2_reg;
    logic signed [18:0] trem_reg;
    logic signed [41:0] ta_reg;
    logic signed [37:0] tb_reg;

    voice_t   rd_data;
    voice_t   wr_data;
    logic     wr_en;
    logic [VW-1:0] wr_addr;
    logic [VW-1:0] rd_addr;
    stage_t   env_stage;
    logic [23:0] env_level;
    env_cfg_t env_cfg;
    logic signed [15:0] rom_data;

    logic          free_found;
    logic [VW-1:0] free_idx;
    logic          act1;
    logic          is_tick;
    logic [31:0]   phase_sel;
    logic          pipe_busy;

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_audio_sample = m_sample_reg;
    assign is_tick        = (cmd_reg == CMD_TICK);
    assign act1           = active_reg[p1_addr];
    assign rd_addr        = cnt_reg[VW-1:0];
    assign pipe_busy      = p1_vld | p2_vld | p3_vld | p4_vld | p5_vld;

    assign env_cfg = '{attack_step:   attack_step_reg,
                       decay_step:    decay_step_reg,
                       sustain_level: sustain_level_reg,
                       release_step:  release_step_reg};

    pss_voice_mem #(.DEPTH(VOICE_COUNT), .AW(VW)) u_mem (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    pss_env u_env (
        .stage      (rd_data.stage),
        .level      (rd_data.level),
        .cfg        (env_cfg),
        .stage_next (env_stage),
        .level_next (env_level)
    );

    pss_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .IW(IW)) u_rom (
        .aclk (aclk),
        .addr (p2_prod[32 +: IW]),
        .data (rom_data)
    );

    // Lowest-numbered free voice for a note-on.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                free_found = 1'b1;
                free_idx   = VW'(i);
            end
        end
    end

    // Write-back port: a new voice on note-on, otherwise the voice that the
    // pipeline's first stage has just read.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = p1_addr;
        wr_data = rd_data;
        if (state_reg == S_NOTE_ON) begin
            wr_en   = free_found;
            wr_addr = free_idx;
            wr_data = '{pitch: pitch_reg, tag: tag_reg, velocity: vel_reg,
                        phase: 32'd0, stage: ST_ATTACK, level: 24'd0};
        end else if (p1_vld && !p1_lfo && act1) begin
            if (is_tick) begin
                wr_en         = 1'b1;
                wr_data.stage = env_stage;
                wr_data.level = env_level;
                wr_data.phase = rd_data.phase + pitch_tab[rd_data.pitch];
            end else if (rd_data.tag == tag_reg) begin
                wr_en         = 1'b1;
                wr_data.stage = ST_RELEASE;
            end
        end
    end

    // The LFO rides the pipeline as one extra slot after the voices, read a
    // quarter turn ahead so the sine table gives its cosine.
    assign phase_sel = p1_lfo ? (lfo_phase_reg + 32'h4000_0000) : rd_data.phase;

    // Control: sequencer state, active flags, LFO phase and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            active_reg    <= '0;
            lfo_phase_reg <= 32'd0;
            m_valid_reg   <= 1'b0;
            p1_vld        <= 1'b0;
            p2_vld        <= 1'b0;
            p3_vld        <= 1'b0;
            p4_vld        <= 1'b0;
            p5_vld        <= 1'b0;
        end else begin
            // A finished sample loads the output register once it is free or
            // being taken; otherwise a taken sample empties it.
            priority if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= m_valid_reg;
            end
            p1_vld <= (state_reg == S_SWEEP);
            p2_vld <= p1_vld && is_tick && (p1_lfo || act1);
            p3_vld <= p2_vld;
            p4_vld <= p3_vld && !p3_lfo;
            p5_vld <= p4_vld;
            if (p1_vld && !p1_lfo && act1 && is_tick && env_stage == ST_OFF) begin
                active_reg[p1_addr] <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    cnt_reg <= '0;
                    if (s_valid) begin
                        priority case (s_command)
                            CMD_NOTE_ON:  state_reg <= S_NOTE_ON;
                            CMD_NOTE_OFF: state_reg <= S_SWEEP;
                            CMD_TICK:     state_reg <= S_SWEEP;
                            default:      state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_NOTE_ON: begin
                    if (free_found) begin
                        active_reg[free_idx] <= 1'b1;
                    end
                    state_reg <= S_IDLE;
                end
                S_SWEEP: begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if ((is_tick && cnt_reg == LFO_SLOT) ||
                        (!is_tick && cnt_reg == LAST_V)) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!pipe_busy) begin
                        state_reg <= is_tick ? S_MIX0 : S_IDLE;
                    end
                end
                S_MIX0: begin
                    lfo_phase_reg <= lfo_phase_reg + lfo_phase_step_reg;
                    state_reg     <= S_MIX1;
                end
                S_MIX1: state_reg <= S_MIX2;
                S_MIX2: state_reg <= S_MIX3;
                S_MIX3: state_reg <= S_OUT;
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath: the captured word, the voice pipeline and the mixing chain.
    logic signed [17:0] lfo_sine_c;
    logic signed [17:0] tri_d;
    logic [16:0]        tri_abs;
    logic [16:0]        lfo_val_c;
    logic signed [56:0] gain_sum;
    logic signed [59:0] trem_sum;
    logic signed [43:0] s3;
    logic signed [44:0] round_sum;
    logic signed [29:0] rounded;
    logic signed [15:0] sat;

    always_comb begin
        lfo_sine_c = 18'sd32768 - 18'(lfo_sin_reg);
        tri_d      = $signed({1'b0, lfo_phase_reg[31:16], 1'b0}) - 18'sd65536;
        tri_abs    = tri_d[17] ? 17'(-tri_d) : tri_d[16:0];
        unique case (lfo_shape_reg)
            LFO_TRIANGLE: lfo_val_c = 17'd65536 - tri_abs;
            LFO_SQUARE:   lfo_val_c = lfo_phase_reg[31] ? 17'd0 : 17'd65536;
            LFO_SAW:      lfo_val_c = {1'b0, lfo_phase_reg[31:16]};
            default:      lfo_val_c = lfo_sine_c[16:0];
        endcase
        gain_sum  = (57'(ga_reg) <<< 18) + 57'(gb_reg);
        trem_sum  = (60'(ta_reg) <<< 18) + 60'(tb_reg);
        s3        = trem_sum[59:16];
        round_sum = 45'(s3) + 45'sd16384;
        rounded   = round_sum[44:15];
        if (rounded > 30'sd32767) begin
            sat = 16'sd32767;
        end else if (rounded < -30'sd32768) begin
            sat = -16'sd32768;
        end else begin
            sat = rounded[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            cmd_reg   <= s_command;
            pitch_reg <= s_note_pitch;
            vel_reg   <= s_note_velocity;
            tag_reg   <= s_note_tag;
            acc_reg   <= 64'sd0;
        end else if (p5_vld) begin
            acc_reg <= acc_reg + 64'(p5_m2);
        end
        p1_lfo  <= (cnt_reg == LFO_SLOT);
        p1_addr <= cnt_reg[VW-1:0];
        p2_lfo  <= p1_lfo;
        p2_prod <= 49'(phase_sel) * 49'(DEPTH_K);
        p2_vel  <= rd_data.velocity;
        p2_lvl  <= env_level;
        p3_lfo  <= p2_lfo;
        p3_vel  <= p2_vel;
        p3_lvl  <= p2_lvl;
        p4_m1   <= 34'(rom_data) * 34'($signed({1'b0, p3_vel}));
        p4_lvl  <= p3_lvl;
        p5_m2   <= 58'(p4_m1) * 58'($signed({1'b0, p4_lvl}));
        if (p3_vld && p3_lfo) begin
            lfo_sin_reg <= rom_data;
        end
        unique case (state_reg)
            S_MIX0: begin
                lfo_val_reg <= lfo_val_c;
                ga_reg <= 38'($signed(acc_reg[63:44])) *
                          38'($signed({1'b0, master_gain_reg}));
                gb_reg <= 37'($signed({1'b0, acc_reg[43:26]})) *
                          37'($signed({1'b0, master_gain_reg}));
            end
            S_MIX1: begin
                trem_prod_reg <= 34'(tremolo_depth_reg) * 34'(17'd65536 - lfo_val_reg);
                s2_reg        <= gain_sum[56:16];
            end
            S_MIX2: begin
                trem_reg <= 19'sd65536 - $signed({1'b0, trem_prod_reg[33:16]});
            end
            S_MIX3: begin
                ta_reg <= 42'($signed(s2_reg[40:18])) * 42'(trem_reg);
                tb_reg <= 38'($signed({1'b0, s2_reg[17:0]})) * 38'(trem_reg);
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_sample_reg <= sat;
                end
            end
            default: ;
        endcase
    end

endmodule
